// ===== design/clb_pkg.sv =====
package clb_pkg;

  // fixed field widths
  localparam int ATOM_W   = 12;
  localparam int IDX_W    = 12;
  localparam int POS_W    = 32;
  localparam int FRAC_W   = 24;
  localparam int CPS_W    = 5;

  // atom numbers are stored as they come: 12 bits cover every atom
  localparam int MAX_ATOMS = 4096;

  localparam int                 MAX_SIDE_DEF = 16;
  localparam logic [CPS_W-1:0]   CPS_RESET    = 5'd16;
  localparam logic [FRAC_W-1:0]  HALF_Q24     = 24'h800000;

  // generation tag kept with each head; a wrap forces a clearing pass
  localparam int EPOCH_W = 4;

  // depth of the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic               valid;
    logic [EPOCH_W-1:0] tag;
    logic [ATOM_W-1:0]  atom;
  } head_entry_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ISSUE,
    ST_LOOKUP
  } back_state_e;

endpackage

// ===== design/clb_ram.sv =====
module clb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/clb_fifo.sv =====
module clb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? PW'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? PW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/clb_front.sv =====
module clb_front #(
  parameter int MW     = 5,
  parameter int CELL_W = 12,
  parameter int ITEM_W = 1 + CELL_W + clb_pkg::ATOM_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        hold_i,
  input  logic [clb_pkg::ATOM_W-1:0]  atom_i,
  input  logic [clb_pkg::POS_W-1:0]   pos_x_i,
  input  logic [clb_pkg::POS_W-1:0]   pos_y_i,
  input  logic [clb_pkg::POS_W-1:0]   pos_z_i,
  input  logic                        new_build_i,
  input  logic [MW-1:0]               side_i,
  output logic                        item_valid_o,
  output logic [ITEM_W-1:0]           item_o,
  input  logic                        item_full_i
);

  localparam int FW = clb_pkg::FRAC_W;

  // frac(x + 0.5) * M, keeping the integer part
  function automatic logic [MW-1:0] to_cell(logic [clb_pkg::POS_W-1:0] pos,
                                            logic [MW-1:0] m);
    logic [FW-1:0]    frac;
    logic [FW+MW-1:0] prod;
    frac = pos[FW-1:0] + clb_pkg::HALF_Q24;
    prod = (FW+MW)'(frac) * (FW+MW)'(m);
    return prod[FW+MW-1:FW];
  endfunction

  logic                       v1_q, v2_q;
  logic                       adv1, adv2, acc;
  logic [clb_pkg::ATOM_W-1:0] atom1_q, atom2_q;
  logic                       nb1_q, nb2_q;
  logic [MW-1:0]              cx1_q, cy1_q, cz1_q, cx2_q;
  logic [2*MW-1:0]            t2_q;
  logic [3*MW-1:0]            cell_full;

  assign adv2   = !v2_q || !item_full_i;
  assign adv1   = !v1_q || adv2;
  assign full_o = !adv1 || hold_i;
  assign acc    = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= acc;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      atom1_q <= atom_i;
      nb1_q   <= new_build_i;
      cx1_q   <= to_cell(pos_x_i, side_i);
      cy1_q   <= to_cell(pos_y_i, side_i);
      cz1_q   <= to_cell(pos_z_i, side_i);
    end
    if (adv2 && v1_q) begin
      atom2_q <= atom1_q;
      nb2_q   <= nb1_q;
      cx2_q   <= cx1_q;
      t2_q    <= (2*MW)'(cy1_q) + (2*MW)'(cz1_q) * (2*MW)'(side_i);
    end
  end

  // cx + (cy + cz*M)*M
  assign cell_full    = (3*MW)'(cx2_q) + (3*MW)'(t2_q) * (3*MW)'(side_i);
  assign item_valid_o = v2_q;
  assign item_o       = {nb2_q, cell_full[CELL_W-1:0], atom2_q};

endmodule

// ===== design/clb_back.sv =====
module clb_back #(
  parameter int NCELLS = 4096,
  parameter int CELL_W = 12,
  parameter int ITEM_W = 1 + CELL_W + clb_pkg::ATOM_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_empty_i,
  input  logic [ITEM_W-1:0]           item_i,
  output logic                        item_pop_o,
  output logic                        sweeping_o,
  output logic                        res_valid_o,
  input  logic                        res_pop_i,
  output logic [clb_pkg::ATOM_W-1:0]  res_atom_o,
  output logic [CELL_W-1:0]           res_cell_o,
  output logic [clb_pkg::ATOM_W-1:0]  res_next_o,
  output logic                        res_next_valid_o
);

  localparam int AW = clb_pkg::ATOM_W;
  localparam int EW = clb_pkg::EPOCH_W;
  localparam int HW = $bits(clb_pkg::head_entry_t);
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(NCELLS - 1);

  clb_pkg::back_state_e state_q, state_d;
  logic [EW-1:0]        epoch_q, epoch_d;
  logic [CELL_W-1:0]    sweep_q, sweep_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        cur_atom_q, cur_atom_d;
  logic [CELL_W-1:0]    cur_cell_q, cur_cell_d;
  logic                 res_valid_q, res_valid_d;
  logic [AW-1:0]        res_atom_q, res_atom_d, res_next_q, res_next_d;
  logic [CELL_W-1:0]    res_cell_q, res_cell_d;
  logic                 res_nv_q, res_nv_d;

  logic [AW-1:0]        q_atom;
  logic [CELL_W-1:0]    q_cell;
  logic                 q_nb;
  logic                 slot_free;

  logic                 we, re;
  logic [CELL_W-1:0]    waddr, raddr;
  clb_pkg::head_entry_t wentry, head;
  logic [HW-1:0]        rdata;

  assign q_atom = item_i[AW-1:0];
  assign q_cell = item_i[AW+CELL_W-1:AW];
  assign q_nb   = item_i[ITEM_W-1];
  assign head   = clb_pkg::head_entry_t'(rdata);

  // the result register frees up in the same cycle it is taken
  assign slot_free = !res_valid_q || res_pop_i;

  clb_ram #(
    .WIDTH (HW),
    .DEPTH (NCELLS)
  ) u_heads (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (HW'(wentry)),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    epoch_d     = epoch_q;
    sweep_d     = sweep_q;
    pend_d      = pend_q;
    cur_atom_d  = cur_atom_q;
    cur_cell_d  = cur_cell_q;
    res_valid_d = res_valid_q && !res_pop_i;
    res_atom_d  = res_atom_q;
    res_cell_d  = res_cell_q;
    res_next_d  = res_next_q;
    res_nv_d    = res_nv_q;
    item_pop_o  = 1'b0;
    we          = 1'b0;
    waddr       = sweep_q;
    wentry      = '0;
    re          = 1'b0;
    raddr       = q_cell;

    case (state_q)
      clb_pkg::ST_SWEEP: begin
        we = 1'b1;
        if (sweep_q == LAST_CELL) begin
          sweep_d = '0;
          pend_d  = 1'b0;
          state_d = pend_q ? clb_pkg::ST_ISSUE : clb_pkg::ST_IDLE;
        end else begin
          sweep_d = CELL_W'(sweep_q + 1'b1);
        end
      end
      clb_pkg::ST_IDLE: begin
        if (!item_empty_i) begin
          item_pop_o = 1'b1;
          cur_atom_d = q_atom;
          cur_cell_d = q_cell;
          if (q_nb && (epoch_q == {EW{1'b1}})) begin
            // tag space used up: wipe all heads before this atom goes in
            epoch_d = '0;
            pend_d  = 1'b1;
            state_d = clb_pkg::ST_SWEEP;
          end else begin
            if (q_nb) begin
              epoch_d = EW'(epoch_q + 1'b1);
            end
            re      = 1'b1;
            state_d = clb_pkg::ST_LOOKUP;
          end
        end
      end
      clb_pkg::ST_ISSUE: begin
        re      = 1'b1;
        raddr   = cur_cell_q;
        state_d = clb_pkg::ST_LOOKUP;
      end
      clb_pkg::ST_LOOKUP: begin
        if (slot_free) begin
          we          = 1'b1;
          waddr       = cur_cell_q;
          wentry      = '{valid: 1'b1, tag: epoch_q, atom: cur_atom_q};
          res_valid_d = 1'b1;
          res_atom_d  = cur_atom_q;
          res_cell_d  = cur_cell_q;
          res_nv_d    = head.valid && (head.tag == epoch_q);
          res_next_d  = (head.valid && (head.tag == epoch_q)) ? head.atom : '0;
          state_d     = clb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = clb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clb_pkg::ST_SWEEP;
      epoch_q     <= '0;
      sweep_q     <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      sweep_q     <= sweep_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_atom_q <= cur_atom_d;
    cur_cell_q <= cur_cell_d;
    res_atom_q <= res_atom_d;
    res_cell_q <= res_cell_d;
    res_next_q <= res_next_d;
    res_nv_q   <= res_nv_d;
  end

  assign sweeping_o       = (state_q == clb_pkg::ST_SWEEP);
  assign res_valid_o      = res_valid_q;
  assign res_atom_o       = res_atom_q;
  assign res_cell_o       = res_cell_q;
  assign res_next_o       = res_next_q;
  assign res_next_valid_o = res_nv_q;

endmodule

// ===== design/cell_list_binning.sv =====
// path: a pushed atom goes through the front stages, the queue, a read of the cell head memory and the result register
// the back end reads then writes the cell head memory for each atom before it takes the next one from the queue
// reset: a pass clears the heads of all MAX_SIDE^3 cells (4096 at default), full stays high
// every 16th new_build repeats that pass before its atom is placed, stalling the back end
// cells_per_side resets to 16; the configuration channel is always ready
module cell_list_binning #(
  parameter int MAX_SIDE = clb_pkg::MAX_SIDE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [clb_pkg::ATOM_W-1:0]  atom_index_i,
  input  logic signed [clb_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [clb_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [clb_pkg::POS_W-1:0] pos_z_i,
  input  logic                        new_build_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [clb_pkg::ATOM_W-1:0]  atom_echo_o,
  output logic [clb_pkg::IDX_W-1:0]   cell_index_o,
  output logic [clb_pkg::ATOM_W-1:0]  next_atom_o,
  output logic                        next_valid_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [clb_pkg::CPS_W-1:0]   cells_per_side_i
);

  localparam int MW     = $clog2(MAX_SIDE + 1);
  localparam int NCELLS = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int CELL_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int ITEM_W = 1 + CELL_W + clb_pkg::ATOM_W;
  localparam int IW     = clb_pkg::IDX_W;

  logic [clb_pkg::CPS_W-1:0] cps_q;
  logic [MW-1:0]             side;
  logic                      f_valid, q_full, q_empty, q_pop, sweeping, res_valid;
  logic [ITEM_W-1:0]         f_item, q_item;
  logic [CELL_W-1:0]         res_cell;
  logic [CELL_W+IW-1:0]      res_cell_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q <= clb_pkg::CPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cps_q <= cells_per_side_i;
    end
  end

  // zero acts as one cell, anything above the built size as the built size
  always_comb begin
    if (cps_q == '0) begin
      side = MW'(1);
    end else if (32'(cps_q) > 32'(MAX_SIDE)) begin
      side = MW'(MAX_SIDE);
    end else begin
      side = MW'(cps_q);
    end
  end

  clb_front #(
    .MW     (MW),
    .CELL_W (CELL_W),
    .ITEM_W (ITEM_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .hold_i       (sweeping),
    .atom_i       (atom_index_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .new_build_i  (new_build_i),
    .side_i       (side),
    .item_valid_o (f_valid),
    .item_o       (f_item),
    .item_full_i  (q_full)
  );

  clb_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (clb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_item),
    .empty_o (q_empty)
  );

  clb_back #(
    .NCELLS (NCELLS),
    .CELL_W (CELL_W),
    .ITEM_W (ITEM_W)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_empty_i     (q_empty),
    .item_i           (q_item),
    .item_pop_o       (q_pop),
    .sweeping_o       (sweeping),
    .res_valid_o      (res_valid),
    .res_pop_i        (pop),
    .res_atom_o       (atom_echo_o),
    .res_cell_o       (res_cell),
    .res_next_o       (next_atom_o),
    .res_next_valid_o (next_valid_o)
  );

  assign res_cell_ext = (CELL_W + IW)'(res_cell);
  assign cell_index_o = res_cell_ext[IW-1:0];
  assign empty        = !res_valid;

endmodule

// ===== design/clb_checker.sv =====
module clb_checker #(
  parameter int MAX_SIDE = clb_pkg::MAX_SIDE_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [clb_pkg::ATOM_W-1:0]  atom_echo_o,
  input logic [clb_pkg::IDX_W-1:0]   cell_index_o,
  input logic [clb_pkg::ATOM_W-1:0]  next_atom_o,
  input logic                        next_valid_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [clb_pkg::CPS_W-1:0]   cells_per_side_i
);

  logic [clb_pkg::CPS_W-1:0] cps_q;
  logic [7:0]                open_q;
  logic [5:0]                m;
  logic [15:0]               cube;
  logic                      in_xfer, out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q  <= clb_pkg::CPS_RESET;
      open_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cps_q <= cells_per_side_i;
      end
      open_q <= 8'(open_q + 8'(in_xfer) - 8'(out_xfer));
    end
  end

  always_comb begin
    if (cps_q == '0) begin
      m = 6'd1;
    end else if (32'(cps_q) > 32'(MAX_SIDE)) begin
      m = 6'(MAX_SIDE);
    end else begin
      m = 6'(cps_q);
    end
    cube = 16'(m) * 16'(m) * 16'(m);
  end

  // every shown result belongs to an atom already taken in
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (open_q != '0))
    else $error("result shown with no atom outstanding");

  a_empty_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !next_valid_o) |-> (next_atom_o == '0))
    else $error("end-of-list result carries a nonzero link");

  a_cell_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (16'(cell_index_o) < cube))
    else $error("cell index beyond the configured grid");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(atom_echo_o) && $stable(cell_index_o)
                          && $stable(next_atom_o) && $stable(next_valid_o)))
    else $error("waiting result changed before its transfer");

endmodule

bind cell_list_binning clb_checker #(.MAX_SIDE(MAX_SIDE)) u_clb_checker (.*);
